// File: hdl/rhw_pkg.sv
package rhw_pkg;

    localparam int MAX_ROWS = 16;
    localparam int MAX_COLS = 16;
    localparam int ADDR_W   = $clog2(MAX_ROWS * MAX_COLS);

    localparam int POS_W  = 4;
    localparam int SIZE_W = 5;
    localparam int CNT_W  = 16;
    localparam int DIR_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 2'd2;

    localparam logic [1:0] ST_EXIT  = 2'd0;
    localparam logic [1:0] ST_BACK  = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;

    localparam logic [DIR_W-1:0] DIR_N = 2'd0;
    localparam logic [DIR_W-1:0] DIR_E = 2'd1;
    localparam logic [DIR_W-1:0] DIR_S = 2'd2;
    localparam logic [DIR_W-1:0] DIR_W_ = 2'd3;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_WALK = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             is_wall;
        logic [DIR_W-1:0] start_dir;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] moves;
        logic [POS_W-1:0] final_row;
        logic [POS_W-1:0] final_col;
        logic [DIR_W-1:0] final_dir;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic cell_write;
        logic walk_init;
        logic act;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic at_exit;
        logic at_back;
        logic at_limit;
    } t_stat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] row,
                                                     input logic [POS_W-1:0] col);
        cell_addr = ADDR_W'(int'(row) * MAX_COLS + int'(col));
    endfunction

endpackage

// File: hdl/right_hand_wall_follower.sv
// Channel   Direction  Handshake                    Payload
// item      in         i_start & !o_busy            i_item   (t_in_item)
// result    out        o_done, one cycle, no stall  o_result (t_out_item)
// config    in         i_cfg_valid & o_cfg_ready    i_cfg_index, i_cfg_data
//
// A load beat leaves o_busy low, so loads may come every cycle while no walk runs.
// A walk repeats a wall read, then a decide step, until it ends, with o_busy high
// from accept to the o_done beat; iterations <= step_limit.
// The iteration loop runs through the registered two-port wall store.
// Synchronous active-low reset clears the grid to open and the registers to
// rows 12, cols 12, step limit 1024. The result beat cannot be stalled.
module right_hand_wall_follower (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  rhw_pkg::t_in_item             i_item,
    output logic                          o_done,
    output rhw_pkg::t_out_item            o_result,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rhw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rhw_pkg::CNT_W-1:0]     i_cfg_data
);

    rhw_pkg::t_cmd  cmd;
    rhw_pkg::t_stat stat;

    assign o_cfg_ready = !o_busy;

    rhw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_mode  (i_item.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    rhw_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_item),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule

// File: hdl/rhw_wall_store.sv
module rhw_wall_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [rhw_pkg::ADDR_W-1:0] i_waddr,
    input  logic                       i_wdata,
    input  logic [rhw_pkg::ADDR_W-1:0] i_raddr_a,
    input  logic [rhw_pkg::ADDR_W-1:0] i_raddr_b,
    output logic                       o_rdata_a,
    output logic                       o_rdata_b
);

    localparam int DEPTH = rhw_pkg::MAX_ROWS * rhw_pkg::MAX_COLS;

    logic             r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic             r_rd_a;
    logic             r_rd_b;

    // unwritten cells read as open
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_valid[i_raddr_a] & r_mem[i_raddr_a];
        r_rd_b <= r_valid[i_raddr_b] & r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

// File: hdl/rhw_datapath.sv
module rhw_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rhw_pkg::t_cmd                 i_cmd,
    output rhw_pkg::t_stat                o_stat,
    input  rhw_pkg::t_in_item             i_item,
    output rhw_pkg::t_out_item            o_result,
    input  logic                          i_cfg_we,
    input  logic [rhw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rhw_pkg::CNT_W-1:0]     i_cfg_data
);

    localparam int POS_W  = rhw_pkg::POS_W;
    localparam int SIZE_W = rhw_pkg::SIZE_W;
    localparam int CNT_W  = rhw_pkg::CNT_W;
    localparam int DIR_W  = rhw_pkg::DIR_W;

    logic [SIZE_W-1:0] r_grid_rows;
    logic [SIZE_W-1:0] r_grid_cols;
    logic [CNT_W-1:0]  r_step_limit;

    logic [SIZE_W-1:0] r_rows;
    logic [SIZE_W-1:0] r_cols;
    logic [POS_W-1:0]  r_row;
    logic [POS_W-1:0]  r_col;
    logic [DIR_W-1:0]  r_dir;
    logic [POS_W-1:0]  r_org_row;
    logic [POS_W-1:0]  r_org_col;
    logic [CNT_W-1:0]  r_moves;
    logic [CNT_W-1:0]  r_iter;
    logic [1:0]        r_status;

    logic [SIZE_W-1:0] used_rows;
    logic [SIZE_W-1:0] used_cols;
    logic [DIR_W-1:0]  dir_rt;
    logic [SIZE_W-1:0] rt_row;
    logic [SIZE_W-1:0] rt_col;
    logic [SIZE_W-1:0] st_row;
    logic [SIZE_W-1:0] st_col;
    logic              rt_in;
    logic              st_in;
    logic              rt_wall;
    logic              st_wall;
    logic              at_start;
    logic              on_border;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows  <= SIZE_W'(12);
            r_grid_cols  <= SIZE_W'(12);
            r_step_limit <= CNT_W'(1024);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rhw_pkg::CFG_GRID_ROWS:  r_grid_rows  <= i_cfg_data[SIZE_W-1:0];
                rhw_pkg::CFG_GRID_COLS:  r_grid_cols  <= i_cfg_data[SIZE_W-1:0];
                rhw_pkg::CFG_STEP_LIMIT: r_step_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_grid_rows == '0) begin
            used_rows = SIZE_W'(1);
        end else if (int'(r_grid_rows) > rhw_pkg::MAX_ROWS) begin
            used_rows = SIZE_W'(rhw_pkg::MAX_ROWS);
        end else begin
            used_rows = r_grid_rows;
        end
        if (r_grid_cols == '0) begin
            used_cols = SIZE_W'(1);
        end else if (int'(r_grid_cols) > rhw_pkg::MAX_COLS) begin
            used_cols = SIZE_W'(rhw_pkg::MAX_COLS);
        end else begin
            used_cols = r_grid_cols;
        end
    end

    // neighbor cells; row/col -1 wraps to all ones, which fails the range check
    assign dir_rt = r_dir + DIR_W'(1);
    assign rt_row = {1'b0, r_row} + SIZE_W'(dir_rt == rhw_pkg::DIR_S)
                                  - SIZE_W'(dir_rt == rhw_pkg::DIR_N);
    assign rt_col = {1'b0, r_col} + SIZE_W'(dir_rt == rhw_pkg::DIR_E)
                                  - SIZE_W'(dir_rt == rhw_pkg::DIR_W_);
    assign st_row = {1'b0, r_row} + SIZE_W'(r_dir == rhw_pkg::DIR_S)
                                  - SIZE_W'(r_dir == rhw_pkg::DIR_N);
    assign st_col = {1'b0, r_col} + SIZE_W'(r_dir == rhw_pkg::DIR_E)
                                  - SIZE_W'(r_dir == rhw_pkg::DIR_W_);
    assign rt_in  = (rt_row < r_rows) && (rt_col < r_cols);
    assign st_in  = (st_row < r_rows) && (st_col < r_cols);

    rhw_wall_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (i_cmd.cell_write && int'(i_item.row) < rhw_pkg::MAX_ROWS
                                     && int'(i_item.col) < rhw_pkg::MAX_COLS),
        .i_waddr   (rhw_pkg::cell_addr(i_item.row, i_item.col)),
        .i_wdata   (i_item.is_wall),
        .i_raddr_a (rhw_pkg::cell_addr(rt_row[POS_W-1:0], rt_col[POS_W-1:0])),
        .i_raddr_b (rhw_pkg::cell_addr(st_row[POS_W-1:0], st_col[POS_W-1:0])),
        .o_rdata_a (rt_wall),
        .o_rdata_b (st_wall)
    );

    assign at_start  = (r_row == r_org_row) && (r_col == r_org_col);
    assign on_border = (r_row == '0) || ({1'b0, r_row} == r_rows - SIZE_W'(1))
                    || (r_col == '0) || ({1'b0, r_col} == r_cols - SIZE_W'(1));

    assign o_stat.at_exit  = on_border && !at_start;
    assign o_stat.at_back  = at_start && (r_moves != '0);
    assign o_stat.at_limit = r_iter >= r_step_limit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_rows    <= used_rows;
            r_cols    <= used_cols;
            r_row     <= i_item.row;
            r_col     <= i_item.col;
            r_org_row <= i_item.row;
            r_org_col <= i_item.col;
            r_dir     <= i_item.start_dir;
            r_moves   <= '0;
            r_iter    <= '0;
        end else if (i_cmd.act) begin
            if (rt_in && !rt_wall) begin
                r_row   <= rt_row[POS_W-1:0];
                r_col   <= rt_col[POS_W-1:0];
                r_dir   <= dir_rt;
                r_moves <= r_moves + CNT_W'(1);
            end else if (st_in && !st_wall) begin
                r_row   <= st_row[POS_W-1:0];
                r_col   <= st_col[POS_W-1:0];
                r_moves <= r_moves + CNT_W'(1);
            end else begin
                r_dir <= r_dir - DIR_W'(1);
            end
            r_iter <= r_iter + CNT_W'(1);
        end
        if (i_cmd.finish) begin
            if (o_stat.at_exit) begin
                r_status <= rhw_pkg::ST_EXIT;
            end else if (o_stat.at_back) begin
                r_status <= rhw_pkg::ST_BACK;
            end else begin
                r_status <= rhw_pkg::ST_LIMIT;
            end
        end
    end

    assign o_result.status    = r_status;
    assign o_result.moves     = r_moves;
    assign o_result.final_row = r_row;
    assign o_result.final_col = r_col;
    assign o_result.final_dir = r_dir;

    a_iter_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.act |=> r_iter == $past(r_iter) + CNT_W'(1))
        else $error("iteration count did not advance");

    a_move_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.act |=> ((r_moves != $past(r_moves)) ==
                       ({r_row, r_col} != $past({r_row, r_col}))))
        else $error("move count and position disagree");

endmodule

// File: hdl/rhw_ctrl.sv
module rhw_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_mode,
    input  rhw_pkg::t_stat i_stat,
    output rhw_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DECIDE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;
    logic   r_done, n_done;
    logic   walk_end;

    assign walk_end = i_stat.at_exit || i_stat.at_back || i_stat.at_limit;

    always_comb begin
        o_cmd.cell_write = i_start && !r_busy && (i_mode == rhw_pkg::MODE_LOAD);
        o_cmd.walk_init  = i_start && !r_busy && (i_mode == rhw_pkg::MODE_WALK);
        o_cmd.act        = (r_state == S_DECIDE);
        o_cmd.finish     = (r_state == S_CHECK) && walk_end;
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.walk_init) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (walk_end) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: n_state = S_CHECK;
            default:  n_state = S_IDLE;
        endcase
        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_done  <= n_done;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

    a_done_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_CHECK && walk_end))
        else $error("result beat without a finished walk");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("result beat while busy");

endmodule

// File: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ROWS  = rhw_pkg::MAX_ROWS;
    localparam int MAX_COLS  = rhw_pkg::MAX_COLS;
    localparam int POS_W     = rhw_pkg::POS_W;
    localparam int SIZE_W    = rhw_pkg::SIZE_W;
    localparam int CNT_W     = rhw_pkg::CNT_W;
    localparam int DIR_W     = rhw_pkg::DIR_W;
    localparam int CFG_IDX_W = rhw_pkg::CFG_IDX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class maze_scoreboard;
        bit                 walls [MAX_ROWS][MAX_COLS];
        logic [SIZE_W-1:0]  grid_rows  = 5'd12;
        logic [SIZE_W-1:0]  grid_cols  = 5'd12;
        logic [CNT_W-1:0]   step_limit = 16'd1024;
        rhw_pkg::t_out_item expected_walks [$];
        int                 errors;

        function int used_rows();
            if (grid_rows == 0) return 1;
            return (grid_rows > MAX_ROWS) ? MAX_ROWS : int'(grid_rows);
        endfunction

        function int used_cols();
            if (grid_cols == 0) return 1;
            return (grid_cols > MAX_COLS) ? MAX_COLS : int'(grid_cols);
        endfunction

        function int pending();
            return expected_walks.size();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] data);
            case (idx)
                rhw_pkg::CFG_GRID_ROWS:  grid_rows  = data[SIZE_W-1:0];
                rhw_pkg::CFG_GRID_COLS:  grid_cols  = data[SIZE_W-1:0];
                rhw_pkg::CFG_STEP_LIMIT: step_limit = data;
                default: ;
            endcase
        endfunction

        function void neighbor(input int r, input int c, input logic [DIR_W-1:0] d,
                               output int nr, output int nc);
            nr = r;
            nc = c;
            case (d)
                rhw_pkg::DIR_N: nr = r - 1;
                rhw_pkg::DIR_E: nc = c + 1;
                rhw_pkg::DIR_S: nr = r + 1;
                default:        nc = c - 1;
            endcase
        endfunction

        function bit open_cell(int r, int c, int rows, int cols);
            if (r < 0 || c < 0 || r >= rows || c >= cols) return 1'b0;
            return !walls[r][c];
        endfunction

        // right-hand rule: right turn and step, else straight step, else turn left
        function rhw_pkg::t_out_item walk(rhw_pkg::t_in_item it);
            int                 rows;
            int                 cols;
            int                 r;
            int                 c;
            int                 nr;
            int                 nc;
            int                 iter;
            bit                 at_start;
            bit                 on_border;
            logic [DIR_W-1:0]   hd;
            logic [DIR_W-1:0]   rt;
            logic [CNT_W-1:0]   mv;
            rhw_pkg::t_out_item res;
            rows = used_rows();
            cols = used_cols();
            r    = it.row;
            c    = it.col;
            hd   = it.start_dir;
            mv   = '0;
            iter = 0;
            while (1) begin
                at_start  = (r == it.row) && (c == it.col);
                on_border = (r == 0) || (r == rows - 1) || (c == 0) || (c == cols - 1);
                if (on_border && !at_start) begin
                    res.status = rhw_pkg::ST_EXIT;
                    break;
                end
                if (at_start && mv != 0) begin
                    res.status = rhw_pkg::ST_BACK;
                    break;
                end
                if (iter >= step_limit) begin
                    res.status = rhw_pkg::ST_LIMIT;
                    break;
                end
                rt = hd + 2'd1;
                neighbor(r, c, rt, nr, nc);
                if (open_cell(nr, nc, rows, cols)) begin
                    r  = nr;
                    c  = nc;
                    hd = rt;
                    mv = mv + 1'b1;
                end else begin
                    neighbor(r, c, hd, nr, nc);
                    if (open_cell(nr, nc, rows, cols)) begin
                        r  = nr;
                        c  = nc;
                        mv = mv + 1'b1;
                    end else begin
                        hd = hd - 2'd1;
                    end
                end
                iter++;
            end
            res.moves     = mv;
            res.final_row = POS_W'(r);
            res.final_col = POS_W'(c);
            res.final_dir = hd;
            return res;
        endfunction

        function void note_item(rhw_pkg::t_in_item it);
            if (it.mode == rhw_pkg::MODE_LOAD) begin
                walls[it.row][it.col] = it.is_wall;
            end else begin
                expected_walks.push_back(walk(it));
            end
        endfunction

        function void check_result(rhw_pkg::t_out_item got);
            rhw_pkg::t_out_item want;
            if (expected_walks.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display({"walk result with none outstanding: ",
                              "status=%0d moves=%0d pos=%0d,%0d dir=%0d"},
                             got.status, got.moves, got.final_row, got.final_col, got.final_dir);
                end
                return;
            end
            want = expected_walks.pop_front();
            if (got.status !== want.status || got.moves !== want.moves ||
                got.final_row !== want.final_row || got.final_col !== want.final_col ||
                got.final_dir !== want.final_dir) begin
                errors++;
                if (errors <= 10) begin
                    $display("walk mismatch: exp status=%0d moves=%0d pos=%0d,%0d dir=%0d",
                             want.status, want.moves, want.final_row, want.final_col,
                             want.final_dir);
                    $display("               got status=%0d moves=%0d pos=%0d,%0d dir=%0d",
                             got.status, got.moves, got.final_row, got.final_col,
                             got.final_dir);
                end
            end
        endfunction

        function void final_check();
            if (expected_walks.size() != 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0d walk results never arrived", expected_walks.size());
                end
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_start     = 1'b0;
    rhw_pkg::t_in_item     i_item      = '0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CNT_W-1:0]      i_cfg_data  = '0;
    logic                  o_busy;
    logic                  o_done;
    rhw_pkg::t_out_item    o_result;
    logic                  o_cfg_ready;

    maze_scoreboard sb = new();
    int             idle_pct;

    right_hand_wall_follower u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            sb.check_result(o_result);
        end
    end

    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic rhw_pkg::t_in_item load_item(input int r, input int c, input bit w);
        rhw_pkg::t_in_item it;
        it.mode      = rhw_pkg::MODE_LOAD;
        it.row       = POS_W'(r);
        it.col       = POS_W'(c);
        it.is_wall   = w;
        it.start_dir = DIR_W'($urandom_range(0, 3));
        return it;
    endfunction

    function automatic rhw_pkg::t_in_item walk_item(input int r, input int c,
                                                    input logic [DIR_W-1:0] d);
        rhw_pkg::t_in_item it;
        it.mode      = rhw_pkg::MODE_WALK;
        it.row       = POS_W'(r);
        it.col       = POS_W'(c);
        it.is_wall   = 1'($urandom_range(0, 1));
        it.start_dir = d;
        return it;
    endfunction

    // mostly maze building inside the grid in use, walks from cells in it
    function automatic rhw_pkg::t_in_item random_item();
        int rows;
        int cols;
        rows = sb.used_rows();
        cols = sb.used_cols();
        if ($urandom_range(0, 99) < 70) begin
            if ($urandom_range(0, 99) < 85) begin
                return load_item($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                                 $urandom_range(0, 99) < 35);
            end
            return load_item($urandom_range(0, 15), $urandom_range(0, 15),
                             1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 99) < 90) begin
            return walk_item($urandom_range(0, rows - 1), $urandom_range(0, cols - 1),
                             DIR_W'($urandom_range(0, 3)));
        end
        return walk_item($urandom_range(0, 15), $urandom_range(0, 15),
                         DIR_W'($urandom_range(0, 3)));
    endfunction

    function automatic logic [CNT_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return 16'd16;
            3:       return 16'd31;
            4:       return CNT_W'($urandom);
            default: return CNT_W'($urandom_range(3, 16));
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return 16'd1;
            1:       return CNT_W'($urandom_range(0, 8));
            default: return CNT_W'($urandom_range(20, 300));
        endcase
    endfunction

    task automatic send_item(input rhw_pkg::t_in_item it);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        sb.note_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int n_items;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 8;

        // open grid: tight loop back to start, border starts, corner
        send_item(walk_item(5, 5, rhw_pkg::DIR_N));
        send_item(walk_item(0, 0, rhw_pkg::DIR_E));
        send_item(walk_item(11, 11, rhw_pkg::DIR_W_));
        send_item(load_item(15, 15, 1'b1));
        send_item(load_item(0, 0, 1'b1));
        // standing on a wall, start outside the grid in use
        send_item(walk_item(0, 0, rhw_pkg::DIR_S));
        send_item(walk_item(15, 15, rhw_pkg::DIR_N));
        // boxed-in start cell
        send_item(load_item(4, 5, 1'b1));
        send_item(load_item(6, 5, 1'b1));
        send_item(load_item(5, 4, 1'b1));
        send_item(load_item(5, 6, 1'b1));
        send_item(walk_item(5, 5, rhw_pkg::DIR_E));
        send_item(load_item(4, 5, 1'b0));
        send_item(load_item(6, 5, 1'b0));
        send_item(load_item(5, 4, 1'b0));
        send_item(load_item(5, 6, 1'b0));

        write_reg(CFG_UNUSED, CNT_W'($urandom));
        write_reg(rhw_pkg::CFG_STEP_LIMIT, 16'd0);
        send_item(walk_item(6, 6, rhw_pkg::DIR_N));
        write_reg(rhw_pkg::CFG_GRID_ROWS, 16'd0);
        write_reg(rhw_pkg::CFG_GRID_COLS, 16'd0);
        write_reg(rhw_pkg::CFG_STEP_LIMIT, 16'd5);
        send_item(walk_item(0, 0, rhw_pkg::DIR_E));
        write_reg(rhw_pkg::CFG_GRID_ROWS, 16'd31);
        write_reg(rhw_pkg::CFG_GRID_COLS, 16'd16);
        write_reg(rhw_pkg::CFG_STEP_LIMIT, 16'd1024);
        send_item(walk_item(7, 7, rhw_pkg::DIR_S));
        send_item(load_item(0, 0, 1'b0));

        for (int ph = 0; ph < 12; ph++) begin
            idle_pct = (ph < 4) ? 8 : (ph < 8) ? 72 : 0;
            write_reg(rhw_pkg::CFG_GRID_ROWS, pick_size());
            write_reg(rhw_pkg::CFG_GRID_COLS, pick_size());
            if (ph == 6) begin
                write_reg(rhw_pkg::CFG_STEP_LIMIT, 16'hFFFF);
                for (int k = 0; k < 3; k++) begin
                    send_item(walk_item($urandom_range(0, sb.used_rows() - 1),
                                        $urandom_range(0, sb.used_cols() - 1),
                                        DIR_W'($urandom_range(0, 3))));
                end
            end else begin
                write_reg(rhw_pkg::CFG_STEP_LIMIT, pick_limit());
                n_items = 125;
                for (int k = 0; k < n_items; k++) begin
                    send_item(random_item());
                end
            end
        end

        i_start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.final_check();
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
